@@ rtl/core/cead_pkg.sv @@
// Shared types and constants for the count entropy and uniqueness block.
// Used by the controller, the datapath and the top level; no dependencies.
package cead_pkg;

    localparam int unsigned CNT_W       = 32;
    localparam int unsigned OUT_TDATA_W = 120;

    // ln 2 in unsigned Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;     // latch a count and update the side totals
        logic norm;       // normalize count and divisor, seed the divider
        logic step_log;   // one squaring step on both logs, one divider step
        logic sub_d;      // form log2(n) - log2(c)
        logic mul_g;      // scale the difference by ln 2
        logic add_g;      // combine the ln 2 partial products
        logic mul_t;      // multiply by the probability
        logic acc;        // add the term into the entropy total
        logic frac_init;  // seed the divider for the unique fraction
        logic frac_step;  // one divider step
        logic out_load;   // capture the result and clear the layer
    } cead_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_term;  // latched count gives a nonzero entropy term
        logic last;       // latched count closes the layer
    } cead_sts_t;

endpackage

@@ rtl/core/cead_dp.sv @@
// Datapath: accumulators, two log2 squaring lanes, restoring divider,
// multiplier stages and result register. Depends on cead_pkg.
module cead_dp #(
    parameter int unsigned MAX_ITEMS   = 65536,
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 27
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [cead_pkg::CNT_W-1:0]        count_in,
    input  logic                              last_in,
    input  logic                              cfg_wr_en,
    input  logic [31:0]                       cfg_wr_data,
    input  cead_pkg::cead_cmd_t               cmd,
    output cead_pkg::cead_sts_t               sts,
    output logic [cead_pkg::OUT_TDATA_W-1:0]  out_data
);
    import cead_pkg::*;

    localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam int unsigned UniqCap   = (MAX_ITEMS < 131071) ? MAX_ITEMS : 131071;
    localparam logic [16:0] UniqCapV  = 17'(UniqCap);
    localparam int unsigned TermShift = 32 - FRAC_BITS;

    logic [31:0] num_symbols_reg;
    logic [31:0] c_reg;
    logic        last_reg;
    logic [39:0] entropy_acc_reg;
    logic [47:0] sum_acc_reg;
    logic [16:0] unique_acc_reg;
    logic        error_reg;
    logic [31:0] mc_reg, mn_reg, fc_reg, fn_reg;
    logic [4:0]  ec_reg, en_reg;
    logic [47:0] div_r_reg, div_d_reg;
    logic [32:0] div_num_reg, div_q_reg;
    logic [36:0] d_reg;
    logic [36:0] ph_reg;
    logic [31:0] pl_reg;
    logic [37:0] g_reg;
    logic [37:0] tp_hi_reg;
    logic [31:0] tp_lo_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic [31:0] c_in;
    logic [48:0] sum_ext;
    logic [36:0] nc_c, nc_n;
    logic [32:0] lc_m, ln_m;
    logic        lc_b, ln_b;
    logic [48:0] r2;
    logic        qbit;
    logic [36:0] ln_c, ln_n;
    logic [63:0] pl_full, tl_full;
    logic [38:0] t_sum;
    logic [38:0] term;
    logic [40:0] ent_sum;
    logic [16:0] frac_val;
    logic [31:0] ent_out;

    // Leading-one normalize: returns {exponent, mantissa with bit 31 set}
    function automatic logic [36:0] norm32(input logic [31:0] x);
        logic [31:0] v;
        logic [4:0]  e;
        v = x;
        e = 5'd31;
        if (v[31:16] == 16'd0) begin v = v << 16; e = e - 5'd16; end
        if (v[31:24] == 8'd0)  begin v = v << 8;  e = e - 5'd8;  end
        if (v[31:28] == 4'd0)  begin v = v << 4;  e = e - 5'd4;  end
        if (v[31:30] == 2'd0)  begin v = v << 2;  e = e - 5'd2;  end
        if (v[31] == 1'b0)     begin v = v << 1;  e = e - 5'd1;  end
        return {e, v};
    endfunction

    // One squaring step of the log2 fraction: returns {bit, new mantissa}
    function automatic logic [32:0] sq_step(input logic [31:0] m);
        logic [63:0] sq;
        logic [32:0] s;
        sq = 64'(m) * 64'(m);
        s  = sq[63:31];
        if (s[32]) return {1'b1, s[32:1]};
        else       return {1'b0, s[31:0]};
    endfunction

    assign c_in    = count_in & CountMask;
    assign sum_ext = 49'(sum_acc_reg) + 49'(c_in);
    assign nc_c    = norm32(c_reg);
    assign nc_n    = norm32(num_symbols_reg);
    assign lc_m    = sq_step(mc_reg);
    assign ln_m    = sq_step(mn_reg);
    assign lc_b    = lc_m[32];
    assign ln_b    = ln_m[32];
    assign r2      = {div_r_reg, div_num_reg[32]};
    assign qbit    = (r2 >= {1'b0, div_d_reg});
    assign ln_c    = {ec_reg, fc_reg};
    assign ln_n    = {en_reg, fn_reg};
    assign pl_full = 64'(d_reg[31:0]) * 64'(LN2_Q32);
    assign tl_full = 64'(div_q_reg[31:0]) * 64'(g_reg[31:0]);
    assign t_sum   = 39'(tp_hi_reg) + 39'(tp_lo_reg);
    assign term    = t_sum >> TermShift;
    assign ent_sum = 41'(entropy_acc_reg) + 41'(term);
    assign ent_out = (entropy_acc_reg > 40'hFF_FFFF_FFFF >> 8) ? 32'hFFFF_FFFF
                                                               : entropy_acc_reg[31:0];

    // Clamp the unique fraction, zero for an empty layer
    always_comb begin
        if (sum_acc_reg == 48'd0)           frac_val = 17'd0;
        else if (div_q_reg > 33'd65536)     frac_val = 17'd65536;
        else                                frac_val = div_q_reg[16:0];
    end

    assign sts.need_term = (c_reg != 32'd0) && (c_reg < num_symbols_reg);
    assign sts.last      = last_reg;
    assign out_data      = out_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_symbols_reg <= 32'd1;
        end else if (cfg_wr_en) begin
            num_symbols_reg <= cfg_wr_data;
        end
    end

    // Layer totals: update on accept and on term add, clear on result capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entropy_acc_reg <= '0;
            sum_acc_reg     <= '0;
            unique_acc_reg  <= '0;
            error_reg       <= 1'b0;
        end else if (cmd.out_load) begin
            entropy_acc_reg <= '0;
            sum_acc_reg     <= '0;
            unique_acc_reg  <= '0;
            error_reg       <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (c_in > num_symbols_reg) error_reg <= 1'b1;
                sum_acc_reg <= sum_ext[48] ? 48'hFFFF_FFFF_FFFF : sum_ext[47:0];
                if (c_in == 32'd1 && unique_acc_reg < UniqCapV)
                    unique_acc_reg <= unique_acc_reg + 17'd1;
            end
            if (cmd.acc) begin
                entropy_acc_reg <= ent_sum[40] ? 40'hFF_FFFF_FFFF : ent_sum[39:0];
            end
        end
    end

    // Item latch, log lanes, divider and multiplier stages
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            c_reg    <= c_in;
            last_reg <= last_in;
        end
        if (cmd.norm) begin
            ec_reg      <= nc_c[36:32];
            mc_reg      <= nc_c[31:0];
            en_reg      <= nc_n[36:32];
            mn_reg      <= nc_n[31:0];
            fc_reg      <= '0;
            fn_reg      <= '0;
            div_r_reg   <= 48'(c_reg);
            div_d_reg   <= 48'(num_symbols_reg);
            div_num_reg <= '0;
            div_q_reg   <= '0;
        end
        if (cmd.frac_init) begin
            div_r_reg   <= '0;
            div_d_reg   <= sum_acc_reg;
            div_num_reg <= {unique_acc_reg, 16'd0};
            div_q_reg   <= '0;
        end
        if (cmd.step_log) begin
            mc_reg <= lc_m[31:0];
            mn_reg <= ln_m[31:0];
            fc_reg <= {fc_reg[30:0], lc_b};
            fn_reg <= {fn_reg[30:0], ln_b};
        end
        if (cmd.step_log || cmd.frac_step) begin
            div_r_reg   <= qbit ? 48'(r2 - {1'b0, div_d_reg}) : r2[47:0];
            div_num_reg <= {div_num_reg[31:0], 1'b0};
            div_q_reg   <= {div_q_reg[31:0], qbit};
        end
        if (cmd.sub_d) begin
            d_reg <= (ln_n > ln_c) ? (ln_n - ln_c) : 37'd0;
        end
        if (cmd.mul_g) begin
            ph_reg <= 37'(d_reg[36:32]) * 37'(LN2_Q32);
            pl_reg <= pl_full[63:32];
        end
        if (cmd.add_g) begin
            g_reg <= 38'(ph_reg) + 38'(pl_reg);
        end
        if (cmd.mul_t) begin
            tp_hi_reg <= 38'(div_q_reg[31:0]) * 38'(g_reg[37:32]);
            tp_lo_reg <= tl_full[63:32];
        end
        if (cmd.out_load) begin
            out_reg <= {4'd0, (sum_acc_reg == 48'd0), error_reg, unique_acc_reg,
                        sum_acc_reg, frac_val, ent_out};
        end
    end

endmodule

@@ rtl/core/cead_ctrl.sv @@
// Controller: sequences accept, log/divide iterations, multiplies and the
// result handshake. Depends on cead_pkg.
module cead_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  cead_pkg::cead_sts_t  sts,
    output cead_pkg::cead_cmd_t  cmd
);
    import cead_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_NORM, ST_LOG, ST_SUB, ST_MUL_G, ST_ADD_G,
        ST_MUL_T, ST_ACC, ST_FRAC_INIT, ST_FRAC, ST_OUT
    } state_t;

    localparam logic [5:0] LogLast  = 6'd31;
    localparam logic [5:0] FracLast = 6'd32;

    state_t     state_reg;
    logic [5:0] cnt_reg;
    logic       m_tvalid_reg;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Decode commands from the state
    always_comb begin
        cmd           = '0;
        cmd.accept    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.norm      = (state_reg == ST_NORM);
        cmd.step_log  = (state_reg == ST_LOG);
        cmd.sub_d     = (state_reg == ST_SUB);
        cmd.mul_g     = (state_reg == ST_MUL_G);
        cmd.add_g     = (state_reg == ST_ADD_G);
        cmd.mul_t     = (state_reg == ST_MUL_T);
        cmd.acc       = (state_reg == ST_ACC);
        cmd.frac_init = (state_reg == ST_FRAC_INIT);
        cmd.frac_step = (state_reg == ST_FRAC);
        cmd.out_load  = (state_reg == ST_OUT) && out_free;
    end

    // State, step counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Raise valid on a result load, drop it after the transfer
            if (cmd.out_load)                  m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    priority if (sts.need_term) state_reg <= ST_NORM;
                    else if (sts.last)          state_reg <= ST_FRAC_INIT;
                    else                        state_reg <= ST_IDLE;
                end
                ST_NORM: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_LOG;
                end
                ST_LOG: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == LogLast) state_reg <= ST_SUB;
                end
                ST_SUB:   state_reg <= ST_MUL_G;
                ST_MUL_G: state_reg <= ST_ADD_G;
                ST_ADD_G: state_reg <= ST_MUL_T;
                ST_MUL_T: state_reg <= ST_ACC;
                ST_ACC: begin
                    state_reg <= sts.last ? ST_FRAC_INIT : ST_IDLE;
                end
                ST_FRAC_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_FRAC;
                end
                ST_FRAC: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == FracLast) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/count_entropy_and_uniqueness.sv @@
// Top level of the layer entropy and unique-fraction block.
// Depends on cead_pkg, cead_ctrl and cead_dp.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = count[31:0], s_tlast = last
//  m_        out  m_tvalid/m_tready  m_tdata = result fields, see port comment
//  cfg_      in   cfg_wr_en          cfg_wr_data = num_symbols
//
// A count with a nonzero entropy term passes accept, decide, normalize, 32 log2
// squaring steps (the divider for p runs in the same steps), then five subtract,
// multiply and add stages. A zero, full or out-of-range count passes accept and
// decide only. The last count then runs the unique-fraction divider and result load.
// Reset is synchronous, active low; num_symbols resets to 1. A stalled result
// is held in the output register and blocks only the next layer's result load.
module count_entropy_and_uniqueness #(
    parameter int unsigned MAX_ITEMS   = 65536,
    parameter int unsigned COUNT_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 27
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // count[31:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // entropy_nats[31:0], unique_fraction[48:32], count_sum[96:49],
    // unique_entries[113:97], range_error[114], empty_sum[115], zero[119:116]
    output logic [cead_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [31:0]                       cfg_wr_data
);
    import cead_pkg::*;

    cead_cmd_t cmd;
    cead_sts_t sts;

    cead_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cead_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .count_in    (s_tdata),
        .last_in     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (m_tdata)
    );

endmodule

@@ rtl/core/cead_checker.sv @@
// Port-level checks for count_entropy_and_uniqueness, attached by bind.
// Sees the top level's handshake ports only.
module cead_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // Hold a pending result until it transfers
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // Come out of reset with no result pending
    a_rst_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One count at a time: input closes after each transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A result never appears in the cycle right after an input transfer
    a_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result rose directly after an input transfer");

endmodule

bind count_entropy_and_uniqueness cead_checker u_cead_checker (.*);

@@ tb/tb_count_entropy_and_uniqueness.sv @@
// Self-checking testbench for count_entropy_and_uniqueness: streams layers of counts,
// predicts each layer's entropy, unique fraction, totals and flags, compares results.
// Depends on cead_pkg and the count_entropy_and_uniqueness top level.
`timescale 1ns / 1ps

module tb_count_entropy_and_uniqueness;
    import cead_pkg::*;

    localparam longint unsigned ENT_CAP  = (64'd1 << 40) - 1;
    localparam longint unsigned SUM_CAP  = (64'd1 << 48) - 1;
    localparam int unsigned     UNIQ_CAP = 65536;
    localparam int unsigned     WDOG_MAX = 20000;

    typedef struct packed {
        logic [31:0] count;
        logic        last;
    } count_item_t;

    // Listed from the highest bit down to match m_tdata[115:0]
    typedef struct packed {
        logic        empty_sum;
        logic        range_error;
        logic [16:0] unique_entries;
        logic [47:0] count_sum;
        logic [16:0] unique_fraction;
        logic [31:0] entropy_nats;
    } layer_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    count_entropy_and_uniqueness dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Predictor state
    logic [31:0]     num_sym;
    longint unsigned ent_total;
    longint unsigned sum_total;
    int unsigned     uniq_total;
    bit              err_seen;

    count_item_t   pending_counts[$];
    layer_result_t expected_layers[$];
    int unsigned   mismatches = 0;
    int unsigned   idle_cycles = 0;
    bit            timed_out = 0;
    bit            quiet_src = 0;
    bit            quiet_sink = 0;
    bit            src_hold = 0;

    function automatic longint unsigned log2_fixed(logic [31:0] x);
        int unsigned e;
        longint unsigned m, f;
        e = 31;
        f = 0;
        while (e > 0 && x[e] == 1'b0) e--;
        m = longint'(x) << (31 - e);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd1 << 32)) begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (longint'(e) << 32) | f;
    endfunction

    function automatic longint unsigned nats_term(logic [31:0] c, logic [31:0] n);
        longint unsigned ln_n, ln_c, d, g, p, t;
        ln_n = log2_fixed(n);
        ln_c = log2_fixed(c);
        d = ln_n > ln_c ? ln_n - ln_c : 0;
        g = (d >> 32) * LN2_Q32 + (((d & 64'hFFFF_FFFF) * LN2_Q32) >> 32);
        p = {c, 32'd0} / 64'(n);
        t = p * (g >> 32) + ((p * (g & 64'hFFFF_FFFF)) >> 32);
        return t >> 5;
    endfunction

    // Fold one count into the layer totals; close the layer on last
    function automatic void absorb_count(count_item_t it);
        layer_result_t r;
        longint unsigned fr;
        if (it.count > num_sym) begin
            err_seen = 1;
        end else if (it.count != 0 && it.count != num_sym) begin
            ent_total += nats_term(it.count, num_sym);
            if (ent_total > ENT_CAP) ent_total = ENT_CAP;
        end
        sum_total += it.count;
        if (sum_total > SUM_CAP) sum_total = SUM_CAP;
        if (it.count == 1 && uniq_total < UNIQ_CAP) uniq_total++;
        if (!it.last) return;
        if (sum_total == 0) begin
            fr = 0;
        end else begin
            fr = (longint'(uniq_total) << 16) / sum_total;
            if (fr > 65536) fr = 65536;
        end
        r.entropy_nats    = ent_total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : ent_total[31:0];
        r.unique_fraction = fr[16:0];
        r.count_sum       = sum_total[47:0];
        r.unique_entries  = uniq_total[16:0];
        r.range_error     = err_seen;
        r.empty_sum       = (sum_total == 0);
        expected_layers.push_back(r);
        ent_total = 0;
        sum_total = 0;
        uniq_total = 0;
        err_seen = 0;
    endfunction

    // Drive counts; predict at the accepting edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                absorb_count('{count: s_tdata, last: s_tlast});
            end
            if (!s_tvalid || s_tready) begin
                if (pending_counts.size() > 0 && !src_hold &&
                    (quiet_src || $urandom_range(99) >= 25)) begin
                    count_item_t nx;
                    nx = pending_counts.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nx.count;
                    s_tlast  <= nx.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check results and drive backpressure
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                layer_result_t got, want;
                got = m_tdata[115:0];
                if (expected_layers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_layers.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: ent %h/%h frac %h/%h sum %h/%h",
                                      " uniq %h/%h err %b/%b empty %b/%b"},
                                     want.entropy_nats, got.entropy_nats,
                                     want.unique_fraction, got.unique_fraction,
                                     want.count_sum, got.count_sum,
                                     want.unique_entries, got.unique_entries,
                                     want.range_error, got.range_error,
                                     want.empty_sum, got.empty_sum);
                    end
                end
            end
            m_tready <= quiet_sink || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) timed_out <= 1'b1;
    end

    task automatic push_count(logic [31:0] c, logic l);
        pending_counts.push_back('{count: c, last: l});
    endtask

    // Wait for the queue to drain and all layers to report, then a settling pause
    task automatic drain_all();
        while (pending_counts.size() > 0 || s_tvalid || expected_layers.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_divisor(logic [31:0] n);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        num_sym = n;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Random layer: mostly in-range counts, occasional noise
    task automatic random_layer(int unsigned len);
        logic [31:0] c;
        for (int unsigned i = 0; i < len; i++) begin
            case ($urandom_range(9))
                0: c = 0;
                1, 2: c = 1;
                3: c = $urandom();
                4: c = num_sym;
                default: c = (num_sym == 0) ? 0 : $urandom_range(num_sym, 0);
            endcase
            push_count(c, i == len - 1);
        end
    endtask

    initial begin
        num_sym = 1;
        ent_total = 0;
        sum_total = 0;
        uniq_total = 0;
        err_seen = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset divisor of one: ones are full-probability, larger counts out of range
        push_count(1, 0);
        push_count(0, 0);
        push_count(5, 1);
        push_count(0, 1);

        set_divisor(100);
        push_count(1, 0);
        push_count(50, 0);
        push_count(100, 0);
        push_count(99, 0);
        push_count(101, 0);
        push_count(32'hFFFF_FFFF, 1);
        push_count(0, 0);
        push_count(0, 1);

        // Divisor zero: every nonzero count is out of range
        set_divisor(0);
        push_count(0, 0);
        push_count(1, 1);

        set_divisor(32'hFFFF_FFFF);
        push_count(1, 0);
        push_count(32'hFFFF_FFFF, 0);
        push_count(32'h8000_0000, 0);
        push_count(32'h7FFF_FFFF, 0);
        push_count(32'hFFFF_FFFF, 0);
        push_count(32'hFFFF_FFFE, 1);

        // Hold the sender with a layer queued until every layer has reported
        while (pending_counts.size() > 0 || s_tvalid) @(posedge aclk);
        src_hold = 1;
        push_count(3, 0);
        push_count(32'h0001_0000, 1);
        while (expected_layers.size() > 0) @(posedge aclk);
        src_hold = 0;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_divisor(10);
                1: set_divisor($urandom_range(1000, 2));
                2: set_divisor($urandom());
                default: set_divisor(32'hFFFF_FFFF);
            endcase
            quiet_src = (ph == 1);
            quiet_sink = (ph == 1);
            for (int k = 0; k < 27; k++) random_layer($urandom_range(6, 1));
        end
        drain_all();
        if (mismatches == 0 && !timed_out)
            $display("count_entropy_and_uniqueness regression: pass");
        else
            $display("count_entropy_and_uniqueness regression: fail");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("count_entropy_and_uniqueness regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cead_pkg.sv
rtl/core/cead_dp.sv
rtl/core/cead_ctrl.sv
rtl/core/count_entropy_and_uniqueness.sv
rtl/core/cead_checker.sv
tb/tb_count_entropy_and_uniqueness.sv
